[rtl/core/fixed_block_pool_allocator_top_macros.svh]
// Assertion macros used by the allocator checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence required in the cycle after the antecedent.
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fbpa_pkg.sv]
// Types, constants and helpers of the fixed block pool allocator.
package fbpa_pkg;

  // Pool geometry: the free map is kept as rows of ROW_W slots
  localparam int MAX_SLOTS    = 64;
  localparam int ROW_W        = 8;
  localparam int ROWS         = MAX_SLOTS / ROW_W;
  localparam int SLOT_W       = 6;
  localparam int ROW_LW       = $clog2(ROW_W);
  localparam int ROW_AW       = SLOT_W - ROW_LW;
  localparam int CNT_W        = 7;
  localparam int BYTES_W      = 21;
  localparam int OFS_W        = 26;
  localparam int HEADER_BYTES = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES   = 1'd1;

  // Request operation codes; code 3 is a no-op
  localparam logic [1:0] OP_TAKE   = 2'd0;
  localparam logic [1:0] OP_RETURN = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RC_RD,
    S_RC_EV,
    S_TK_RD,
    S_TK_EV,
    S_RT_RD,
    S_RT_EV,
    S_RESULT
  } state_e;

  // Number of set bits in one free-map row
  function automatic logic [ROW_LW:0] popcount_row(logic [ROW_W-1:0] v);
    logic [ROW_LW:0] c;
    c = '0;
    for (int i = 0; i < ROW_W; i++) begin
      c = c + {{ROW_LW{1'b0}}, v[i]};
    end
    return c;
  endfunction

endpackage

[rtl/core/fixed_block_pool_allocator_top.sv]
// Fixed block pool allocator: next-fit slot search over a row-organized free map.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   tvalid/tready                operation, slot_index
// m_axis    out  tvalid/tready                status, granted_index, data_offset, free_count
// cfg       in   cfg_we_i (no back-pressure)  slots_in_use, slot_bytes
//
// Each row visit is a memory read state, then an evaluate state, on one read port.
// A take visits rows until a hit or a full wrap, a return one row; others skip to S_RESULT.
// A write of slots_in_use triggers a recount of free slots, one row visit
// per managed row, before the next request is taken. Reset needs no sweep: row valid
// bits make unwritten rows read as all free. A result waits in the output register
// while the next request is accepted; the block holds in S_RESULT if it is full.
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request: [1:0] operation, [7:2] slot_index
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  // result: [1:0] status, [7:2] granted_index, [33:8] data_offset,
  // [40:34] free_count, [47:41] zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  // configuration
  logic [CNT_W-1:0]   slots_q;
  logic [BYTES_W-1:0] bytes_q;
  logic               stale_q;
  logic               stale_clr;

  // allocator state
  logic [SLOT_W-1:0]  next_pos_q, next_pos_d;
  logic [CNT_W-1:0]   free_q, free_d;

  // per-request working registers
  logic [ROW_AW-1:0]  row_q, row_d;
  logic               pass_q, pass_d;
  logic [SLOT_W-1:0]  start_q, start_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  status_e            res_status_q, res_status_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic               res_hit_q, res_hit_d;

  // free map memory and row valid bits
  logic [ROW_W-1:0]   mem_q [ROWS];
  logic [ROWS-1:0]    row_vld_q;
  logic [ROW_W-1:0]   rd_data_q;
  logic               rd_vld_q;
  logic               mem_we;
  logic [ROW_W-1:0]   mem_wd;
  logic               vld_clr;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [OFS_W-1:0]   out_ofs_q;
  logic [CNT_W-1:0]   out_free_q;
  logic               out_load;

  // derived values
  logic [CNT_W-1:0]   n_slots;
  logic [CNT_W-1:0]   n_m1_full;
  logic [SLOT_W-1:0]  nm1;
  logic [ROW_AW-1:0]  last_row;
  logic [SLOT_W-1:0]  start_pos;
  logic [ROW_AW-1:0]  start_row;
  logic [ROW_LW-1:0]  start_lo;
  logic [ROW_W-1:0]   row_bits;
  logic [ROW_W-1:0]   lim_mask;
  logic [ROW_W-1:0]   scan_mask;
  logic [ROW_W-1:0]   cand;
  logic               hit;
  logic [ROW_LW-1:0]  hit_j;
  logic [SLOT_W-1:0]  hit_slot;
  logic [1:0]         in_op;
  logic [SLOT_W-1:0]  in_idx;
  logic               in_accept;
  logic               idx_out_of_range;
  logic [BYTES_W:0]   bytes_hdr;
  logic [SLOT_W+BYTES_W:0] prod;
  logic [OFS_W-1:0]   ofs;

  assign in_op     = s_axis_tdata[1:0];
  assign in_idx    = s_axis_tdata[7:2];
  assign s_axis_tready = (state_q == S_IDLE) && !stale_q;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // managed slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (slots_q == '0) begin
      n_slots = CNT_W'(1);
    end else if (slots_q > CNT_W'(MAX_SLOTS)) begin
      n_slots = CNT_W'(MAX_SLOTS);
    end else begin
      n_slots = slots_q;
    end
  end

  assign n_m1_full = n_slots - CNT_W'(1);
  assign nm1       = n_m1_full[SLOT_W-1:0];
  assign last_row  = nm1[SLOT_W-1:ROW_LW];
  assign start_pos = ({1'b0, next_pos_q} < n_slots) ? next_pos_q : '0;
  assign start_row = start_q[SLOT_W-1:ROW_LW];
  assign start_lo  = start_q[ROW_LW-1:0];
  assign idx_out_of_range = ({1'b0, in_idx} >= n_slots);

  // row as read; a never-written row is all free
  assign row_bits = rd_vld_q ? rd_data_q : '1;

  // slot masks for the current row
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      lim_mask[j]  = ({row_q, ROW_LW'(j)} <= nm1);
      scan_mask[j] = lim_mask[j];
      if (row_q == start_row) begin
        if (!pass_q) begin
          scan_mask[j] = lim_mask[j] && (ROW_LW'(j) >= start_lo);
        end else begin
          scan_mask[j] = lim_mask[j] && (ROW_LW'(j) < start_lo);
        end
      end
    end
  end

  assign cand = row_bits & scan_mask;

  // lowest free slot in the row
  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = 0; j < ROW_W; j++) begin
      if (!hit && cand[j]) begin
        hit   = 1'b1;
        hit_j = ROW_LW'(j);
      end
    end
  end

  assign hit_slot = {row_q, hit_j};

  // payload offset of the granted slot
  assign bytes_hdr = {1'b0, bytes_q} + (BYTES_W+1)'(HEADER_BYTES);
  assign prod = {{(BYTES_W+1){1'b0}}, res_slot_q} * {{SLOT_W{1'b0}}, bytes_hdr};
  assign ofs  = prod[OFS_W-1:0] + OFS_W'(HEADER_BYTES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stale_q) begin
          state_d = S_RC_RD;
        end else if (s_axis_tvalid) begin
          priority if (in_op == OP_TAKE) begin
            state_d = S_TK_RD;
          end else if (in_op == OP_RETURN && !idx_out_of_range) begin
            state_d = S_RT_RD;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_RC_RD: state_d = S_RC_EV;
      S_RC_EV: state_d = (row_q == last_row) ? S_IDLE : S_RC_RD;
      S_TK_RD: state_d = S_TK_EV;
      S_TK_EV: begin
        if (hit || (pass_q && row_q == start_row)) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_TK_RD;
        end
      end
      S_RT_RD: state_d = S_RT_EV;
      S_RT_EV: state_d = S_RESULT;
      S_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    next_pos_d   = next_pos_q;
    free_d       = free_q;
    row_d        = row_q;
    pass_d       = pass_q;
    start_d      = start_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_hit_d    = res_hit_q;
    mem_we       = 1'b0;
    mem_wd       = row_bits;
    vld_clr      = 1'b0;
    stale_clr    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (stale_q) begin
          // start recounting free slots from row 0
          stale_clr = 1'b1;
          row_d     = '0;
          free_d    = '0;
        end else if (in_accept) begin
          idx_d        = in_idx;
          start_d      = start_pos;
          row_d        = start_pos[SLOT_W-1:ROW_LW];
          pass_d       = 1'b0;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_hit_d    = 1'b0;
          priority if (in_op == OP_RETURN) begin
            row_d = in_idx[SLOT_W-1:ROW_LW];
            if (idx_out_of_range) begin
              res_status_d = ST_RANGE;
            end
          end else if (in_op == OP_CLEAR) begin
            vld_clr    = 1'b1;
            next_pos_d = '0;
            free_d     = n_slots;
          end else begin
            // take proceeds to the search; code 3 does nothing
          end
        end
      end
      S_RC_EV: begin
        free_d = free_q + CNT_W'(popcount_row(row_bits & lim_mask));
        row_d  = row_q + ROW_AW'(1);
      end
      S_TK_EV: begin
        if (hit) begin
          mem_we     = 1'b1;
          mem_wd     = row_bits & ~(ROW_W'(1) << hit_j);
          free_d     = free_q - CNT_W'(1);
          next_pos_d = (hit_slot == nm1) ? '0 : hit_slot + SLOT_W'(1);
          res_slot_d = hit_slot;
          res_hit_d  = 1'b1;
        end else if (pass_q && row_q == start_row) begin
          res_status_d = ST_NO_FREE;
        end else if (!pass_q && row_q == last_row) begin
          // wrap to the start of the pool
          row_d  = '0;
          pass_d = 1'b1;
        end else begin
          row_d = row_q + ROW_AW'(1);
        end
      end
      S_RT_EV: begin
        if (row_bits[idx_q[ROW_LW-1:0]]) begin
          res_status_d = ST_ALREADY_FREE;
        end else begin
          mem_we = 1'b1;
          mem_wd = row_bits | (ROW_W'(1) << idx_q[ROW_LW-1:0]);
          free_d = free_q + CNT_W'(1);
        end
      end
      S_RESULT: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
        // read cycles only wait for the memory
      end
    endcase
  end

  // free map memory, one row read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[row_q] <= mem_wd;
    end
    rd_data_q <= mem_q[row_q];
  end

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[row_q];
      if (vld_clr) begin
        row_vld_q <= '0;
      end else if (mem_we) begin
        row_vld_q[row_q] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= CNT_W'(MAX_SLOTS);
      bytes_q <= BYTES_W'(4096);
      stale_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_SLOTS_IN_USE) begin
        slots_q <= cfg_wdata_i[CNT_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_SLOT_BYTES) begin
        bytes_q <= cfg_wdata_i[BYTES_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_SLOTS_IN_USE) begin
        stale_q <= 1'b1;
      end else if (stale_clr) begin
        stale_q <= 1'b0;
      end
    end
  end

  // control and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      next_pos_q <= '0;
      free_q     <= CNT_W'(MAX_SLOTS);
      row_q      <= '0;
      pass_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_pos_q <= next_pos_d;
      free_q     <= free_d;
      row_q      <= row_d;
      pass_q     <= pass_d;
    end
  end

  // request working registers
  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_hit_q    <= res_hit_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_hit_q ? res_slot_q : '0;
      out_ofs_q    <= res_hit_q ? ofs : '0;
      out_free_q   <= free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_free_q, out_ofs_q, out_slot_q, out_status_q};

endmodule

[rtl/core/fbpa_checker.sv]
// Port-level checks of the fixed block pool allocator, bound to the top level.
`include "fixed_block_pool_allocator_top_macros.svh"

module fbpa_checker
  import fbpa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [47:0]           m_axis_tdata
);

  // one request in flight: no request is taken in the cycle after one
  `FBPA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted back to back")

  // failed results carry no slot and no offset
  `FBPA_ASSERT(a_fail_no_grant, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == 32'd0, "failed result carries a grant")

  // free count never exceeds the pool depth and padding stays zero
  `FBPA_ASSERT(a_free_bounded, m_axis_tvalid |-> m_axis_tdata[40:34] <= 7'(MAX_SLOTS) && m_axis_tdata[47:41] == 7'd0, "free count or padding out of range")

  // a stalled result holds
  `FBPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
